FILE: rtl/ucts_pkg.sv
package ucts_pkg;

  // Transaction opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DONE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Token PIDs
  localparam logic [7:0] PID_SETUP = 8'h2D;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'hE1;

  // Control word fields
  localparam logic [10:0] LEN_MASK   = 11'h7FF;
  localparam logic [31:0] BIT_ACTIVE = 32'h1 << 23;
  localparam logic [31:0] BIT_IOC    = 32'h1 << 24;
  localparam logic [31:0] ERR_COUNT3 = 32'h3 << 27;

  localparam logic [10:0] SETUP_LEN = 11'd8;
  localparam logic [31:0] TIMEOUT_RESET = 32'd20000000;

  // Transfer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SETUP  = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_STATUS = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] request_length;
    logic       data_dir_in;
    logic [6:0] device_address;
    logic       status_stalled;
    logic       status_babble;
    logic       status_crc_timeout;
  } in_item_t;

  typedef struct packed {
    logic        arm_phase;
    logic [31:0] token_word;
    logic [31:0] control_word;
    logic        transfer_done;
    logic        transfer_ok;
  } out_item_t;

  // Build the descriptor token; toggle shares bit 23 with the length field
  function automatic logic [31:0] pack_token(logic [7:0] pid, logic [6:0] addr,
                                             logic [10:0] len, logic toggle);
    logic [10:0] len_m1;
    len_m1 = (len - 11'd1) & LEN_MASK;
    return {24'd0, pid} | {17'd0, addr, 8'd0} | ({31'd0, toggle} << 23)
           | {len_m1, 21'd0};
  endfunction

  function automatic logic [31:0] pack_control(logic [10:0] len);
    return {21'd0, len & LEN_MASK} | BIT_IOC | ERR_COUNT3 | BIT_ACTIVE;
  endfunction

endpackage

FILE: rtl/ucts_core.sv
module ucts_core import ucts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output out_item_t   result
);

  phase_t      phase, phase_next;
  logic [9:0]  saved_length;
  logic        saved_dir_in;
  logic [6:0]  saved_address;
  logic [31:0] poll_count, poll_count_next;
  logic [31:0] timeout_limit;

  logic        err;
  logic        tick_expired;
  logic [6:0]  addr_use;
  logic        dir_use;

  assign err = item.status_stalled | item.status_babble | item.status_crc_timeout;
  assign tick_expired = ({1'b0, poll_count} + 33'd1) >= {1'b0, timeout_limit};
  // A start uses the fresh address in the same transaction
  assign addr_use = (item.opcode == OP_START) ? item.device_address : saved_address;
  assign dir_use  = saved_dir_in;

  // Phase transition and word pack
  always_comb begin
    phase_next      = phase;
    poll_count_next = poll_count;
    result          = '0;
    case (item.opcode)
      OP_START: begin
        phase_next          = PH_SETUP;
        poll_count_next     = '0;
        result.arm_phase    = 1'b1;
        result.token_word   = pack_token(PID_SETUP, addr_use, SETUP_LEN, 1'b0);
        result.control_word = pack_control(SETUP_LEN);
      end
      OP_DONE: begin
        if (phase != PH_IDLE) begin
          if (err || phase == PH_STATUS) begin
            phase_next           = PH_IDLE;
            poll_count_next      = '0;
            result.transfer_done = 1'b1;
            result.transfer_ok   = !err;
          end else if (phase == PH_SETUP && saved_length != 10'd0) begin
            phase_next          = PH_DATA;
            poll_count_next     = '0;
            result.arm_phase    = 1'b1;
            result.token_word   = pack_token(dir_use ? PID_IN : PID_OUT, addr_use,
                                             {1'b0, saved_length}, 1'b1);
            result.control_word = pack_control({1'b0, saved_length});
          end else begin
            phase_next          = PH_STATUS;
            poll_count_next     = '0;
            result.arm_phase    = 1'b1;
            result.token_word   = pack_token(dir_use ? PID_OUT : PID_IN, addr_use,
                                             11'd0, 1'b1);
            result.control_word = pack_control(11'd0);
          end
        end
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (tick_expired) begin
            phase_next           = PH_IDLE;
            poll_count_next      = '0;
            result.transfer_done = 1'b1;
          end else begin
            poll_count_next = poll_count + 32'd1;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Advance state on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      poll_count    <= '0;
      saved_length  <= '0;
      saved_dir_in  <= 1'b0;
      saved_address <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      poll_count <= poll_count_next;
      if (item.opcode == OP_START) begin
        saved_length  <= item.request_length;
        saved_dir_in  <= item.data_dir_in;
        saved_address <= item.device_address;
      end
    end
  end

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_wdata;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    fire && result.transfer_done |=> phase == PH_IDLE && poll_count == '0)
    else $error("finished transfer did not return to idle");

  a_start_arms_setup: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OP_START |=> phase == PH_SETUP && poll_count == '0)
    else $error("start did not arm setup");

  a_saved_hold: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode != OP_START |=> $stable(saved_length) && $stable(saved_address))
    else $error("latched transfer fields changed without start");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_IDLE && item.opcode != OP_START |-> result == '0)
    else $error("idle block produced a non-empty result");

endmodule

FILE: rtl/ucts_out_reg.sv
module ucts_out_reg import ucts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_data,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  assign can_load = !out_valid || out_ready;

  // Hold the result until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_data <= load_data;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    can_load && load |=> out_valid)
    else $error("loaded result not presented");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    !can_load |-> out_valid)
    else $error("output register blocked while empty");

endmodule

FILE: rtl/usb_control_transfer_sequencer_top.sv
// Path: an input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; the result register stalls the input
//   register only while a result waits on out_ready.
// Reset (rst, synchronous, active high): phase idle, latched fields and poll
//   count zero, timeout_limit 20000000, both pipeline stages empty.
module usb_control_transfer_sequencer_top import ucts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      can_load;
  logic      fire;
  out_item_t result;

  assign fire     = stage_valid && can_load;
  assign in_ready = !stage_valid || can_load;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_data;
    end
  end

  ucts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (stage_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  ucts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_data (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb_usb_control_transfer_sequencer_top.sv
`timescale 1ns / 1ps

module tb_usb_control_transfer_sequencer_top;
  import ucts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ERR_NONE  = 3'b000;
  localparam logic [2:0] ERR_STALL = 3'b100;
  localparam logic [2:0] ERR_BABBLE = 3'b010;
  localparam logic [2:0] ERR_CRC   = 3'b001;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // Sequencer shadow state
  phase_t      cur_phase;
  logic [9:0]  sv_len;
  logic        sv_dir;
  logic [6:0]  sv_addr;
  logic [31:0] polls;
  logic [31:0] tmo_limit;

  out_item_t   pending_results[$];
  out_item_t   want;
  int          fail_count = 0;
  int          sent_count = 0;
  int          burst_left = 0;

  // Receiver stall pattern
  int          rdy_mode = 0;
  int          rdy_left = 0;
  logic [3:0]  rdy_tick = '0;

  usb_control_transfer_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("usb_control_transfer_sequencer_top verification failed");
    $finish;
  end

  // Arm a phase: pack token and control words, clear the poll count
  function automatic out_item_t arm_words(logic [7:0] pid, logic [10:0] len, logic tog);
    out_item_t   r;
    logic [10:0] len_m1;
    len_m1 = len - 11'd1;
    r = '0;
    r.arm_phase = 1'b1;
    r.token_word = {len_m1, 21'd0} | {8'd0, tog, 15'd0, pid} | {17'd0, sv_addr, 8'd0};
    r.control_word = {21'd0, len} | BIT_ACTIVE | BIT_IOC | ERR_COUNT3;
    polls = '0;
    return r;
  endfunction

  // End the transfer with a verdict
  function automatic out_item_t end_words(logic ok);
    out_item_t r;
    r = '0;
    r.transfer_done = 1'b1;
    r.transfer_ok = ok;
    cur_phase = PH_IDLE;
    polls = '0;
    return r;
  endfunction

  // Advance the shadow sequencer by one transaction
  function automatic out_item_t next_seq_result(in_item_t it);
    out_item_t r;
    logic      err;
    r = '0;
    err = it.status_stalled | it.status_babble | it.status_crc_timeout;
    case (it.opcode)
      OP_START: begin
        sv_len = it.request_length;
        sv_dir = it.data_dir_in;
        sv_addr = it.device_address;
        cur_phase = PH_SETUP;
        r = arm_words(PID_SETUP, SETUP_LEN, 1'b0);
      end
      OP_DONE: begin
        if (cur_phase != PH_IDLE) begin
          if (err) begin
            r = end_words(1'b0);
          end else if (cur_phase == PH_SETUP && sv_len != '0) begin
            cur_phase = PH_DATA;
            r = arm_words(sv_dir ? PID_IN : PID_OUT, {1'b0, sv_len}, 1'b1);
          end else if (cur_phase != PH_STATUS) begin
            cur_phase = PH_STATUS;
            r = arm_words(sv_dir ? PID_OUT : PID_IN, 11'd0, 1'b1);
          end else begin
            r = end_words(1'b1);
          end
        end
      end
      OP_TICK: begin
        if (cur_phase != PH_IDLE) begin
          if ({1'b0, polls} + 33'd1 >= {1'b0, tmo_limit}) begin
            r = end_words(1'b0);
          end else begin
            polls = polls + 32'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, logic [9:0] len, logic dir,
                                       logic [6:0] addr, logic [2:0] errs);
    in_item_t it;
    it.opcode = op;
    it.request_length = len;
    it.data_dir_in = dir;
    it.device_address = addr;
    {it.status_stalled, it.status_babble, it.status_crc_timeout} = errs;
    return it;
  endfunction

  function automatic in_item_t done_item(logic [2:0] errs);
    return mk_item(OP_DONE, 10'($urandom), 1'($urandom), 7'($urandom), errs);
  endfunction

  function automatic in_item_t tick_item();
    return mk_item(OP_TICK, 10'($urandom), 1'($urandom), 7'($urandom), 3'($urandom));
  endfunction

  function automatic in_item_t rand_start();
    logic [9:0] len;
    case ($urandom_range(0, 5))
      0: len = '0;
      1: len = 10'h3FF;
      default: len = 10'($urandom);
    endcase
    return mk_item(OP_START, len, 1'($urandom), 7'($urandom), 3'($urandom));
  endfunction

  // Send one transaction; bursts with random gaps between them
  task automatic issue_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(next_seq_result(it));
    sent_count++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_timeout_limit(logic [31:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tmo_limit = v;
  endtask

  // Completions, ticks and unused opcode with no transfer running
  task automatic test_idle_ignored();
    issue_item(done_item(ERR_NONE));
    issue_item(tick_item());
    issue_item(mk_item(OP_UNUSED, 10'h3FF, 1'b1, 7'h7F, 3'b111));
  endtask

  // Transfers: full IN data and no-data transfers, then an OUT data one left in status
  task automatic test_transfer_paths();
    issue_item(mk_item(OP_START, 10'h3FF, 1'b1, 7'h7F, ERR_NONE));
    issue_item(tick_item());
    issue_item(done_item(ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(mk_item(OP_START, 10'd0, 1'b0, 7'h00, ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(mk_item(OP_START, 10'd1, 1'b0, 7'h55, ERR_NONE));
    issue_item(mk_item(OP_UNUSED, 10'd0, 1'b0, 7'h00, ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(done_item(ERR_NONE));
  endtask

  // Each error bit fails the phase it is reported on
  task automatic test_phase_errors();
    issue_item(mk_item(OP_START, 10'd8, 1'b1, 7'h01, ERR_NONE));
    issue_item(done_item(ERR_STALL));
    issue_item(mk_item(OP_START, 10'd0, 1'b1, 7'h2A, ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(done_item(ERR_BABBLE));
    issue_item(mk_item(OP_START, 10'd5, 1'b0, 7'h13, ERR_NONE));
    issue_item(done_item(ERR_NONE));
    issue_item(done_item(ERR_CRC));
  endtask

  // Start while busy abandons the running transfer
  task automatic test_restart_busy();
    issue_item(mk_item(OP_START, 10'd8, 1'b1, 7'h2A, ERR_NONE));
    issue_item(mk_item(OP_START, 10'd2, 1'b0, 7'h07, ERR_NONE));
    issue_item(done_item(ERR_NONE));
  endtask

  // Poll limit: zero, small and maximum
  task automatic test_timeout_limits();
    set_timeout_limit(32'd0);
    issue_item(rand_start());
    issue_item(tick_item());
    set_timeout_limit(32'd2);
    issue_item(rand_start());
    issue_item(tick_item());
    issue_item(tick_item());
    set_timeout_limit(32'hFFFF_FFFF);
    issue_item(rand_start());
    issue_item(tick_item());
    issue_item(done_item(ERR_NONE));
  endtask

  // Mostly well-formed transfers with ticks and errors, some noise
  task automatic test_random_traffic();
    int        goal;
    int        next_cfg;
    int        ticks;
    logic [1:0] op;
    goal = sent_count + 650;
    next_cfg = sent_count;
    while (sent_count < goal) begin
      if (sent_count >= next_cfg) begin
        case ($urandom_range(0, 7))
          0: set_timeout_limit(32'd0);
          1: set_timeout_limit(32'd1);
          5: set_timeout_limit(32'hFFFF_FFFF);
          6: set_timeout_limit($urandom_range(7, 40));
          7: set_timeout_limit(TIMEOUT_RESET);
          default: set_timeout_limit($urandom_range(2, 6));
        endcase
        next_cfg += 100;
      end
      if ($urandom_range(0, 4) == 0) begin
        op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
        issue_item(mk_item(op, 10'($urandom), 1'($urandom), 7'($urandom), 3'($urandom)));
      end else begin
        issue_item(rand_start());
        while (cur_phase != PH_IDLE && sent_count < goal) begin
          ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
          for (int k = 0; k < ticks && cur_phase != PH_IDLE; k++) issue_item(tick_item());
          if (cur_phase != PH_IDLE) begin
            if ($urandom_range(0, 11) == 0) begin
              issue_item(rand_start());
            end else begin
              issue_item(done_item(($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7))
                                                               : ERR_NONE));
            end
          end
        end
      end
    end
  endtask

  // Stall the result side on a changing pattern
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(20, 120);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    rdy_tick <= rdy_tick + 4'd1;
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (rdy_tick[2:0] != 3'd0);
      default: out_ready <= (rdy_tick[3:2] == 2'b00);
    endcase
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s expected %h got %h", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("arm_phase", 32'(want.arm_phase), 32'(out_data.arm_phase));
        check_field("token_word", want.token_word, out_data.token_word);
        check_field("control_word", want.control_word, out_data.control_word);
        check_field("transfer_done", 32'(want.transfer_done), 32'(out_data.transfer_done));
        check_field("transfer_ok", 32'(want.transfer_ok), 32'(out_data.transfer_ok));
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cur_phase = PH_IDLE;
    sv_len = '0;
    sv_dir = 1'b0;
    sv_addr = '0;
    polls = '0;
    tmo_limit = TIMEOUT_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_ignored();
    test_transfer_paths();
    test_phase_errors();
    test_restart_busy();
    test_timeout_limits();
    test_random_traffic();

    drain_results();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("usb_control_transfer_sequencer_top verification clean");
    end else begin
      $display("usb_control_transfer_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
